>>> rtl/core/mlpq_pkg.sv
// Shared types, constants and helpers for the multilevel priority FIFO.
// Used by every module of the block except the generic RAM; depends on nothing.
package mlpq_pkg;

  localparam int NUM_LEVELS  = 32;
  localparam int LEVEL_DEPTH = 16;
  localparam int ITEM_WIDTH  = 32;

  localparam int LVL_W  = $clog2(NUM_LEVELS);
  localparam int PTR_W  = $clog2(LEVEL_DEPTH);
  localparam int FILL_W = $clog2(LEVEL_DEPTH + 1);
  localparam int ADDR_W = $clog2(NUM_LEVELS * LEVEL_DEPTH);
  localparam int TOT_W  = $clog2(NUM_LEVELS * LEVEL_DEPTH + 1);

  localparam int CFG_W     = 6;
  localparam int ACT_W     = CFG_W + 1;
  localparam int PADDR_W   = 3;
  localparam int PDATA_W   = 32;
  localparam int IN_ITEM_W = 32;
  localparam int PRIO_W    = 5;
  localparam int CNT_W     = 10;

  localparam logic [CFG_W-1:0] NUM_LEVELS_RESET = CFG_W'(32);
  localparam logic [PADDR_W-1:0] REG_NUM_LEVELS = PADDR_W'(0);

  localparam logic REQ_PUSH = 1'b0;
  localparam logic REQ_POP  = 1'b1;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;
  localparam logic [1:0] ST_FULL  = 2'd3;

  typedef struct packed {
    logic [PTR_W-1:0]  head;
    logic [PTR_W-1:0]  tail;
    logic [FILL_W-1:0] fill;
  } meta_t;

  localparam int META_W = $bits(meta_t);

  function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    if (p == PTR_W'(LEVEL_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + PTR_W'(1);
    end
    return r;
  endfunction

  function automatic logic [ADDR_W-1:0] slot_addr(input logic [LVL_W-1:0] lvl,
                                                  input logic [PTR_W-1:0] ptr);
    logic [ADDR_W-1:0] base;
    base = ADDR_W'(ADDR_W'(lvl) * ADDR_W'(LEVEL_DEPTH));
    return base + ADDR_W'(ptr);
  endfunction

endpackage

>>> rtl/core/mlpq_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
// Standalone; read data holds while no read is issued.
module mlpq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem_r[rd_addr];
    end
  end

endmodule

>>> rtl/core/mlpq_cfg.sv
// APB-style configuration register file holding the number of levels in use.
// Depends on mlpq_pkg for widths, address map and reset value.
module mlpq_cfg import mlpq_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output logic [CFG_W-1:0]   num_levels
);

  logic [CFG_W-1:0] num_levels_r;
  logic             hit;

  assign pready = 1'b1;
  assign hit    = (paddr[PADDR_W-1] == REG_NUM_LEVELS[PADDR_W-1]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_levels_r <= NUM_LEVELS_RESET;
    end else if (psel && penable && pwrite && pready && hit) begin
      num_levels_r <= pwdata[CFG_W-1:0];
    end
  end

  assign prdata     = hit ? PDATA_W'(num_levels_r) : '0;
  assign num_levels = num_levels_r;

endmodule

>>> rtl/core/multilevel_priority_fifo_core.sv
// Multilevel priority FIFO: one ring per level in a shared item RAM, level
// pointers and fill counts in a metadata RAM, a nonempty bitmap in flops.
// A push or a rejected request gives its result from the metadata read (S_META);
// a successful pop reads the metadata, then the item (S_META, then S_DATA).
// One request is in flight at a time; the input stalls until its result is loaded.
// Reset (synchronous, rst_n low) empties all levels at once; no clearing pass.
module multilevel_priority_fifo_core import mlpq_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_req_type,
  input  logic [IN_ITEM_W-1:0]  in_item,
  input  logic [PRIO_W-1:0]     in_priority_req,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [IN_ITEM_W-1:0]  out_popped_item,
  output logic [PRIO_W-1:0]     out_popped_level,
  output logic [1:0]            out_status,
  output logic [CNT_W-1:0]      out_item_count,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [PADDR_W-1:0]    paddr,
  input  logic [PDATA_W-1:0]    pwdata,
  output logic [PDATA_W-1:0]    prdata,
  output logic                  pready
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_META = 2'd1;
  localparam logic [1:0] S_DATA = 2'd2;

  logic [1:0]            state_r, state_nxt;
  logic [CFG_W-1:0]      num_levels;
  logic [ACT_W-1:0]      act_levels;
  logic [LVL_W-1:0]      top_lvl, acc_lvl;
  logic                  accept;

  logic                  req_pop_r, range_bad_r, empty_r;
  logic [ITEM_WIDTH-1:0] item_r;
  logic [LVL_W-1:0]      lvl_r;

  logic [NUM_LEVELS-1:0] nonempty_r, nonempty_nxt;
  logic [NUM_LEVELS-1:0] meta_vld_r;
  logic                  meta_vld_q_r;
  logic [TOT_W-1:0]      total_r, total_nxt;

  logic [META_W-1:0]     meta_rd_data;
  meta_t                 meta_cur, meta_new;
  logic                  meta_wr_en;

  logic                  fifo_wr_en, fifo_rd_en;
  logic [ADDR_W-1:0]     fifo_wr_addr, fifo_rd_addr;
  logic [ITEM_WIDTH-1:0] fifo_rd_data;

  logic                  push_ok, pop_ok, out_free, finish_meta, load_out;
  logic [1:0]            status_meta;
  logic                  out_valid_r, out_valid_nxt;

  mlpq_cfg u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .num_levels (num_levels)
  );

  assign act_levels = ({1'b0, num_levels} > ACT_W'(NUM_LEVELS)) ?
                      ACT_W'(NUM_LEVELS) : {1'b0, num_levels};

  always_comb begin
    top_lvl = '0;
    for (int i = 0; i < NUM_LEVELS; i++) begin
      if (nonempty_r[i]) begin
        top_lvl = LVL_W'(i);
      end
    end
  end

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && (state_r == S_IDLE);
  assign acc_lvl  = (in_req_type == REQ_POP) ? top_lvl : LVL_W'(in_priority_req);

  always_ff @(posedge clk) begin
    if (accept) begin
      req_pop_r   <= (in_req_type == REQ_POP);
      item_r      <= ITEM_WIDTH'(in_item);
      lvl_r       <= acc_lvl;
      range_bad_r <= (ACT_W'(in_priority_req) >= act_levels);
      empty_r     <= (nonempty_r == '0);
    end
  end

  mlpq_ram #(
    .WIDTH (META_W),
    .DEPTH (NUM_LEVELS)
  ) u_meta_ram (
    .clk     (clk),
    .wr_en   (meta_wr_en),
    .wr_addr (lvl_r),
    .wr_data (meta_new),
    .rd_en   (accept),
    .rd_addr (acc_lvl),
    .rd_data (meta_rd_data)
  );

  mlpq_ram #(
    .WIDTH (ITEM_WIDTH),
    .DEPTH (NUM_LEVELS * LEVEL_DEPTH)
  ) u_fifo_ram (
    .clk     (clk),
    .wr_en   (fifo_wr_en),
    .wr_addr (fifo_wr_addr),
    .wr_data (item_r),
    .rd_en   (fifo_rd_en),
    .rd_addr (fifo_rd_addr),
    .rd_data (fifo_rd_data)
  );

  assign meta_cur = meta_vld_q_r ? meta_t'(meta_rd_data) : '0;
  assign out_free = !out_valid_r || !out_stall;

  assign push_ok = !req_pop_r && !range_bad_r && (meta_cur.fill != FILL_W'(LEVEL_DEPTH));
  assign pop_ok  = req_pop_r && !empty_r;

  assign finish_meta = (state_r == S_META) && !pop_ok && out_free;
  assign meta_wr_en  = (state_r == S_META) && (pop_ok || (push_ok && out_free));
  assign fifo_wr_en  = (state_r == S_META) && push_ok && out_free;
  assign fifo_rd_en  = (state_r == S_META) && pop_ok;

  assign fifo_wr_addr = slot_addr(lvl_r, meta_cur.tail);
  assign fifo_rd_addr = slot_addr(lvl_r, meta_cur.head);

  always_comb begin
    meta_new     = meta_cur;
    nonempty_nxt = nonempty_r;
    total_nxt    = total_r;
    if (meta_wr_en) begin
      if (req_pop_r) begin
        meta_new.head = ptr_next(meta_cur.head);
        meta_new.fill = meta_cur.fill - FILL_W'(1);
        if (meta_new.fill == '0) begin
          nonempty_nxt[lvl_r] = 1'b0;
        end
        total_nxt = total_r - TOT_W'(1);
      end else begin
        meta_new.tail = ptr_next(meta_cur.tail);
        meta_new.fill = meta_cur.fill + FILL_W'(1);
        nonempty_nxt[lvl_r] = 1'b1;
        total_nxt = total_r + TOT_W'(1);
      end
    end
  end

  always_comb begin
    if (req_pop_r) begin
      status_meta = ST_EMPTY;
    end else if (range_bad_r) begin
      status_meta = ST_RANGE;
    end else if (push_ok) begin
      status_meta = ST_OK;
    end else begin
      status_meta = ST_FULL;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_META;
        end
      end
      S_META: begin
        if (pop_ok) begin
          state_nxt = S_DATA;
        end else if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      S_DATA: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign load_out      = finish_meta || ((state_r == S_DATA) && out_free);
  assign out_valid_nxt = load_out || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      nonempty_r   <= '0;
      meta_vld_r   <= '0;
      meta_vld_q_r <= 1'b0;
      total_r      <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      nonempty_r  <= nonempty_nxt;
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
      if (accept) begin
        meta_vld_q_r <= meta_vld_r[acc_lvl];
      end
      if (meta_wr_en) begin
        meta_vld_r[lvl_r] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      if (state_r == S_DATA) begin
        out_popped_item  <= IN_ITEM_W'(fifo_rd_data);
        out_popped_level <= PRIO_W'(lvl_r);
        out_status       <= ST_OK;
      end else begin
        out_popped_item  <= '0;
        out_popped_level <= '0;
        out_status       <= status_meta;
      end
      out_item_count <= CNT_W'(total_nxt);
    end
  end

  assign out_valid = out_valid_r;

endmodule

>>> rtl/core/mlpq_checker.sv
// Port-level checker for the multilevel priority FIFO core, bound to the top.
// Depends on mlpq_pkg for status codes and field widths.
module mlpq_checker import mlpq_pkg::*; (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_stall,
  input logic                 out_valid,
  input logic                 out_stall,
  input logic [IN_ITEM_W-1:0] out_popped_item,
  input logic [PRIO_W-1:0]    out_popped_level,
  input logic [1:0]           out_status,
  input logic [CNT_W-1:0]     out_item_count
);

  a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_EMPTY) |-> (out_item_count == '0))
    else $error("pop on empty reported a nonzero item count");

  a_reject_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_OK) |->
      (out_popped_item == '0) && (out_popped_level == '0))
    else $error("rejected transaction carried a popped item or level");

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input not stalled after an accepted transaction");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status)
      && $stable(out_item_count))
    else $error("stalled result changed or dropped");

endmodule

bind multilevel_priority_fifo_core mlpq_checker u_mlpq_checker (.*);

>>> bench/tb_multilevel_priority_fifo_core.sv
`timescale 1ns / 100ps
// Testbench for multilevel_priority_fifo_core: a directed table and randomized
// push and pop traffic, checked against an in-bench model of the level FIFOs.
// Depends on mlpq_pkg and the core RTL only.
module tb_multilevel_priority_fifo_core;
  import mlpq_pkg::*;

  typedef struct packed {
    logic [IN_ITEM_W-1:0] item;
    logic [PRIO_W-1:0]    level;
    logic [1:0]           status;
    logic [CNT_W-1:0]     count;
  } queue_result_t;

  typedef struct {
    bit                   is_cfg;
    logic [CFG_W-1:0]     levels;
    logic                 req;
    logic [IN_ITEM_W-1:0] item;
    logic [PRIO_W-1:0]    prio;
    bit                   typed;
    queue_result_t        want;
  } stim_row_t;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  logic                 in_req_type;
  logic [IN_ITEM_W-1:0] in_item;
  logic [PRIO_W-1:0]    in_priority_req;
  logic                 out_valid;
  logic                 out_stall;
  logic [IN_ITEM_W-1:0] out_popped_item;
  logic [PRIO_W-1:0]    out_popped_level;
  logic [1:0]           out_status;
  logic [CNT_W-1:0]     out_item_count;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [PADDR_W-1:0]   paddr;
  logic [PDATA_W-1:0]   pwdata;
  logic [PDATA_W-1:0]   prdata;
  logic                 pready;

  // Model of the queue state and the level setting.
  logic [ITEM_WIDTH-1:0] item_mem [NUM_LEVELS*LEVEL_DEPTH];
  int                    head_ptr [NUM_LEVELS];
  int                    tail_ptr [NUM_LEVELS];
  int                    level_fill [NUM_LEVELS];
  logic [NUM_LEVELS-1:0] nonempty_levels;
  int                    total_items;
  logic [CFG_W-1:0]      levels_cfg;

  queue_result_t pending_results[$];
  int            errors;
  int            status_seen [4];
  int            idle_pct;
  int            stall_pct;
  bit            hold_active;
  event          start_long_hold;

  multilevel_priority_fifo_core u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_req_type      (in_req_type),
    .in_item          (in_item),
    .in_priority_req  (in_priority_req),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_popped_item  (out_popped_item),
    .out_popped_level (out_popped_level),
    .out_status       (out_status),
    .out_item_count   (out_item_count),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  initial begin
    #5_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic queue_result_t apply_request(input logic req,
                                                  input logic [IN_ITEM_W-1:0] item,
                                                  input logic [PRIO_W-1:0] prio);
    queue_result_t r;
    int act;
    int lvl;
    r = '0;
    act = (levels_cfg > NUM_LEVELS) ? NUM_LEVELS : int'(levels_cfg);
    lvl = 0;
    if (req == REQ_PUSH) begin
      if (int'(prio) >= act) begin
        r.status = ST_RANGE;
      end else if (level_fill[prio] >= LEVEL_DEPTH) begin
        r.status = ST_FULL;
      end else begin
        item_mem[int'(prio) * LEVEL_DEPTH + tail_ptr[prio]] = item;
        tail_ptr[prio] = (tail_ptr[prio] == LEVEL_DEPTH - 1) ? 0 : tail_ptr[prio] + 1;
        level_fill[prio]++;
        nonempty_levels[prio] = 1'b1;
        total_items++;
        r.status = ST_OK;
      end
    end else if (nonempty_levels == '0) begin
      r.status = ST_EMPTY;
    end else begin
      for (int i = NUM_LEVELS - 1; i >= 0; i--) begin
        if (nonempty_levels[i]) begin
          lvl = i;
          break;
        end
      end
      r.item = item_mem[lvl * LEVEL_DEPTH + head_ptr[lvl]];
      r.level = PRIO_W'(lvl);
      head_ptr[lvl] = (head_ptr[lvl] == LEVEL_DEPTH - 1) ? 0 : head_ptr[lvl] + 1;
      level_fill[lvl]--;
      if (level_fill[lvl] == 0) begin
        nonempty_levels[lvl] = 1'b0;
      end
      total_items--;
      r.status = ST_OK;
    end
    r.count = CNT_W'(total_items);
    return r;
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_request(input logic req, input logic [IN_ITEM_W-1:0] item,
                              input logic [PRIO_W-1:0] prio, input bit typed,
                              input queue_result_t want);
    queue_result_t predicted;
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid        <= 1'b1;
    in_req_type     <= req;
    in_item         <= item;
    in_priority_req <= prio;
    do @(posedge clk); while (in_stall);
    predicted = apply_request(req, item, prio);
    pending_results.push_back(typed ? want : predicted);
    @(negedge clk);
  endtask

  task automatic write_num_levels(input logic [CFG_W-1:0] value);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= REG_NUM_LEVELS;
    pwdata  <= PDATA_W'(value);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    levels_cfg = value;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic check_field(input string name, input logic [IN_ITEM_W-1:0] want,
                             input logic [IN_ITEM_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin : result_check
    queue_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, got item %0h status %0d",
                 $time, out_popped_item, out_status);
        errors++;
      end else begin
        want = pending_results.pop_front();
        check_field("popped_item", want.item, out_popped_item);
        check_field("popped_level", IN_ITEM_W'(want.level), IN_ITEM_W'(out_popped_level));
        check_field("status", IN_ITEM_W'(want.status), IN_ITEM_W'(out_status));
        check_field("item_count", IN_ITEM_W'(want.count), IN_ITEM_W'(out_item_count));
        status_seen[want.status]++;
      end
    end
  end

  always @(negedge clk) begin
    out_stall <= hold_active || ($urandom_range(99) < stall_pct);
  end

  initial begin
    forever begin
      @(start_long_hold);
      hold_active = 1'b1;
      repeat (80) @(negedge clk);
      hold_active = 1'b0;
    end
  end

  function automatic stim_row_t req_row(input logic req, input logic [IN_ITEM_W-1:0] item,
                                        input logic [PRIO_W-1:0] prio, input bit typed,
                                        input queue_result_t want);
    stim_row_t row;
    row = '{is_cfg: 1'b0, levels: '0, req: req, item: item, prio: prio,
            typed: typed, want: want};
    return row;
  endfunction

  function automatic stim_row_t cfg_row(input logic [CFG_W-1:0] levels);
    stim_row_t row;
    row = '{is_cfg: 1'b1, levels: levels, req: REQ_PUSH, item: '0, prio: '0,
            typed: 1'b0, want: '0};
    return row;
  endfunction

  initial begin : stimulus
    stim_row_t        directed_rows[$];
    logic [CFG_W-1:0] phase_levels [7];
    int               act;
    int               sent;
    int               pick;
    int               n;
    logic [PRIO_W-1:0]    prio;
    logic [IN_ITEM_W-1:0] item;

    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_req_type     = REQ_PUSH;
    in_item         = '0;
    in_priority_req = '0;
    out_stall       = 1'b0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    errors          = 0;
    idle_pct        = 34;
    stall_pct       = 34;
    hold_active     = 1'b0;
    status_seen     = '{default: 0};
    nonempty_levels = '0;
    total_items     = 0;
    levels_cfg      = NUM_LEVELS_RESET;
    head_ptr        = '{default: 0};
    tail_ptr        = '{default: 0};
    level_fill      = '{default: 0};

    directed_rows.push_back(req_row(REQ_POP, '0, '0, 1, '{'0, '0, ST_EMPTY, 10'd0}));
    directed_rows.push_back(req_row(REQ_PUSH, '0, 5'd0, 1, '{'0, '0, ST_OK, 10'd1}));
    directed_rows.push_back(req_row(REQ_PUSH, '1, 5'd31, 1, '{'0, '0, ST_OK, 10'd2}));
    directed_rows.push_back(req_row(REQ_PUSH, 32'hA5A5_5A5A, 5'd31, 1,
                                    '{'0, '0, ST_OK, 10'd3}));
    directed_rows.push_back(req_row(REQ_PUSH, 32'h0000_0001, 5'd16, 0, '0));
    directed_rows.push_back(req_row(REQ_POP, '0, '0, 1, '{'1, 5'd31, ST_OK, 10'd3}));
    directed_rows.push_back(req_row(REQ_POP, '0, 5'd31, 0, '0));
    directed_rows.push_back(req_row(REQ_POP, '1, '1, 0, '0));
    directed_rows.push_back(req_row(REQ_POP, '0, '0, 1, '{'0, 5'd0, ST_OK, 10'd0}));
    directed_rows.push_back(req_row(REQ_POP, '0, '0, 1, '{'0, '0, ST_EMPTY, 10'd0}));
    directed_rows.push_back(cfg_row(6'd1));
    directed_rows.push_back(req_row(REQ_PUSH, 32'h1234, 5'd1, 1, '{'0, '0, ST_RANGE, 10'd0}));
    directed_rows.push_back(req_row(REQ_PUSH, '1, 5'd31, 1, '{'0, '0, ST_RANGE, 10'd0}));
    directed_rows.push_back(req_row(REQ_PUSH, 32'h8000_0000, 5'd0, 1,
                                    '{'0, '0, ST_OK, 10'd1}));
    directed_rows.push_back(cfg_row(6'd0));
    directed_rows.push_back(req_row(REQ_PUSH, 32'h55, 5'd0, 1, '{'0, '0, ST_RANGE, 10'd1}));
    directed_rows.push_back(req_row(REQ_POP, '0, '0, 1,
                                    '{32'h8000_0000, 5'd0, ST_OK, 10'd0}));
    directed_rows.push_back(cfg_row(6'd32));
    directed_rows.push_back(req_row(REQ_PUSH, 32'hDEAD_BEEF, 5'd20, 0, '0));
    directed_rows.push_back(req_row(REQ_PUSH, 32'h0F0F_F0F0, 5'd3, 0, '0));
    directed_rows.push_back(cfg_row(6'd4));
    directed_rows.push_back(req_row(REQ_PUSH, '1, 5'd20, 1, '{'0, '0, ST_RANGE, 10'd2}));
    directed_rows.push_back(req_row(REQ_POP, '0, '0, 0, '0));
    directed_rows.push_back(req_row(REQ_POP, '0, '0, 0, '0));
    directed_rows.push_back(cfg_row(6'd63));
    directed_rows.push_back(req_row(REQ_PUSH, 32'h7FFF_FFFF, 5'd31, 1,
                                    '{'0, '0, ST_OK, 10'd1}));
    directed_rows.push_back(req_row(REQ_POP, '0, '0, 1,
                                    '{32'h7FFF_FFFF, 5'd31, ST_OK, 10'd0}));

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].is_cfg) begin
        write_num_levels(directed_rows[i].levels);
      end else begin
        send_request(directed_rows[i].req, directed_rows[i].item, directed_rows[i].prio,
                     directed_rows[i].typed, directed_rows[i].want);
      end
    end

    phase_levels = '{6'd32, 6'd1, 6'd63, 6'd0, 6'd7, CFG_W'($urandom_range(32, 1)), 6'd32};
    for (int p = 0; p < 7; p++) begin
      write_num_levels(phase_levels[p]);
      idle_pct  = (p == 4) ? 0 : 34;
      stall_pct = (p == 4) ? 0 : 34;
      if (p == 2) begin
        -> start_long_hold;
      end
      act = (levels_cfg > NUM_LEVELS) ? NUM_LEVELS : int'(levels_cfg);
      sent = 0;
      while (sent < 100) begin
        pick = $urandom_range(9);
        if (act > 0 && $urandom_range(9) < 7) begin
          prio = PRIO_W'($urandom_range(act - 1));
        end else begin
          prio = PRIO_W'($urandom_range(31));
        end
        case ($urandom_range(7))
          0: item = '1;
          1: item = '0;
          default: item = $urandom;
        endcase
        if (pick == 0) begin
          // Overfill one level so the full case is hit when the level is in range.
          repeat (LEVEL_DEPTH + 1) begin
            send_request(REQ_PUSH, $urandom, prio, 0, '0);
          end
          sent += LEVEL_DEPTH + 1;
        end else if (pick == 1) begin
          n = (total_items <= 40) ? total_items + 1 : 20;
          repeat (n) send_request(REQ_POP, $urandom, PRIO_W'($urandom), 0, '0);
          sent += n;
        end else if (pick <= 5) begin
          send_request(REQ_PUSH, item, prio, 0, '0);
          sent++;
        end else begin
          send_request(REQ_POP, item, prio, 0, '0);
          sent++;
        end
      end
    end

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);

    $display("Run covered %0d ok, %0d empty-pop, %0d out-of-range and %0d full-level results",
             status_seen[ST_OK], status_seen[ST_EMPTY], status_seen[ST_RANGE],
             status_seen[ST_FULL]);
    $display("over level settings 0, 1, 4, 7, 32 and 63, with a long output hold-off.");
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/core/mlpq_pkg.sv
rtl/core/mlpq_ram.sv
rtl/core/mlpq_cfg.sv
rtl/core/multilevel_priority_fifo_core.sv
rtl/core/mlpq_checker.sv
bench/tb_multilevel_priority_fifo_core.sv
